// ===== sv/cmca_pkg.sv =====
// ----------------------------------------------------------------------------
// cmca_pkg: shared types and helpers for the coverage map classifier
// Beat layouts, code constants, memory geometry and hit-count bucketing.
// ----------------------------------------------------------------------------
package cmca_pkg;

   // map geometry
   localparam int MAP_ENTRIES = 65536;
   localparam int INDEX_SPACE = 65536;
   localparam int MEM_DEPTH   = (MAP_ENTRIES < INDEX_SPACE) ? MAP_ENTRIES : INDEX_SPACE;
   localparam int MEM_AW      = $clog2(MEM_DEPTH);
   localparam int ROW_BITS    = 32;
   localparam int BIT_AW      = $clog2(ROW_BITS);
   localparam int ROWS        = MEM_DEPTH / ROW_BITS;
   localparam int ROW_AW      = $clog2(ROWS);

   // accumulator widths and limits
   localparam int RUN_W   = 17;
   localparam int TOTAL_W = 48;
   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // opcodes
   localparam logic OP_TRACE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // classification modes
   localparam logic [1:0] MODE_HUMAN = 2'd0;
   localparam logic [1:0] MODE_POW2  = 2'd1;
   localparam logic [1:0] MODE_EDGE  = 2'd2;
   localparam logic [1:0] MODE_RAW   = 2'd3;

   // register indexes
   localparam logic CSR_CLASSIFY_MODE    = 1'b0;
   localparam logic CSR_COLLECT_COVERAGE = 1'b1;

   localparam int CSR_W = 2;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] map_index;
      logic [7:0]  hit_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [7:0]         class_value;
      logic [RUN_W-1:0]   run_tuples;
      logic [TOTAL_W-1:0] grand_total;
      logic [7:0]         highest_value;
      logic               marker_seen;
      logic [RUN_W-1:0]   covered_edges;
      logic               cover_bit;
   } rsp_type;

   // human-readable buckets 0..8
   function automatic logic [7:0] bucket_human(input logic [7:0] v);
      logic [7:0] r;
      if (v < 8'd4)        r = v;
      else if (v < 8'd8)   r = 8'd4;
      else if (v < 8'd16)  r = 8'd5;
      else if (v < 8'd32)  r = 8'd6;
      else if (v < 8'd128) r = 8'd7;
      else                 r = 8'd8;
      return r;
   endfunction

   // power-of-two buckets, everything from 64 up lands in 128
   function automatic logic [7:0] bucket_pow2(input logic [7:0] v);
      logic [7:0] r;
      if (v < 8'd3)       r = v;
      else if (v == 8'd3) r = 8'd4;
      else if (v < 8'd8)  r = 8'd8;
      else if (v < 8'd16) r = 8'd16;
      else if (v < 8'd32) r = 8'd32;
      else if (v < 8'd64) r = 8'd64;
      else                r = 8'd128;
      return r;
   endfunction

   function automatic logic [7:0] classify(input logic [1:0] mode, input logic [7:0] v);
      logic [7:0] r;
      case (mode)
         MODE_HUMAN: r = bucket_human(v);
         MODE_POW2:  r = bucket_pow2(v);
         MODE_EDGE:  r = {7'd0, (v != 8'd0)};
         MODE_RAW:   r = v;
         default:    r = v;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/coverage_map_classify_accumulate_core.sv =====
// ----------------------------------------------------------------------------
// coverage_map_classify_accumulate_core
// Buckets trace hit counts, keeps run/total/max accumulators and merges
// nonzero entries, when collection is on, into a persistent coverage bitmap held in a row memory.
// ----------------------------------------------------------------------------
//
//   channel  signals                         direction  beat
//   req      req_valid/req_ready/req_data    in         one trace byte or read
//   rsp      rsp_valid/rsp_ready/rsp_data    out        one result per request
//   csr      csr_we/csr_index/csr_wdata      in         register write, no wait
//
// One request per cycle sustained unless rsp stalls; a request beat passes
// the bitmap row read, then the classify/update/write-back stage, to rsp.
// Rate is set by the single-port-per-direction bitmap row memory; a
// read-after-write on the same row is covered by a one-entry forward.
// After reset a clearing pass zeroes the bitmap, one row per cycle, over
// all ROWS (2048) rows; req_ready stays low meanwhile, csr writes still land.
// A stalled rsp holds the update stage, which holds req_ready low.
// ----------------------------------------------------------------------------
module coverage_map_classify_accumulate_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cmca_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cmca_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [cmca_pkg::CSR_W-1:0]    csr_wdata
);
   import cmca_pkg::*;

   // control and configuration
   state_type           state_ff, state_in;
   logic [ROW_AW-1:0]   clr_row_ff, clr_row_in;
   logic [1:0]          classify_mode_ff;
   logic                collect_ff;

   // bitmap row memory
   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROW_BITS-1:0] rdata_ff;
   logic                mem_we;
   logic [ROW_AW-1:0]   mem_waddr;
   logic [ROW_BITS-1:0] mem_wdata;

   // last row written, for same-row forwarding
   logic                hold_valid_ff;
   logic [ROW_AW-1:0]   hold_row_ff;
   logic [ROW_BITS-1:0] hold_data_ff;

   // update stage
   logic                s1_valid_ff;
   req_type             s1_req_ff;

   // accumulators
   logic [RUN_W-1:0]    run_ff, run_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [7:0]          max_ff, max_in;
   logic                marker_ff, marker_in;
   logic [RUN_W-1:0]    covered_ff, covered_in;

   // result register
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff, rsp_in;

   logic                accept;
   logic                advance;
   logic                s1_in_map;
   logic                s1_trace;
   logic [ROW_AW-1:0]   s1_row;
   logic [BIT_AW-1:0]   s1_bit;
   logic [ROW_BITS-1:0] row_cur;
   logic [ROW_BITS-1:0] row_new;
   logic [7:0]          raw_v;
   logic [7:0]          cls;
   logic                hit;
   logic                set_new;
   logic [TOTAL_W:0]    total_sum;

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_RUN) && (!s1_valid_ff || advance);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // clearing sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_row_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_row_ff <= clr_row_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_row_in = clr_row_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == ROW_AW'(ROWS - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            clr_row_in = '0;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         classify_mode_ff <= MODE_HUMAN;
         collect_ff       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLASSIFY_MODE:    classify_mode_ff <= csr_wdata[1:0];
            CSR_COLLECT_COVERAGE: collect_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // update-stage decode
   assign s1_in_map = 32'(s1_req_ff.map_index) < MEM_DEPTH;
   assign s1_trace  = (s1_req_ff.opcode == OP_TRACE);
   assign s1_row    = s1_req_ff.map_index[MEM_AW-1:BIT_AW];
   assign s1_bit    = s1_req_ff.map_index[BIT_AW-1:0];

   // forward the row written last when this beat missed it
   assign row_cur = (hold_valid_ff && hold_row_ff == s1_row) ? hold_data_ff : rdata_ff;

   // marker at position zero reads as an empty count
   always_comb begin
      raw_v = s1_req_ff.hit_count;
      if (s1_req_ff.map_index == 16'd0 && raw_v == 8'd1) begin
         raw_v = 8'd0;
      end
   end

   assign cls       = (s1_trace && s1_in_map) ? classify(classify_mode_ff, raw_v) : 8'd0;
   assign hit       = (cls != 8'd0);
   assign set_new   = hit && collect_ff && !row_cur[s1_bit];
   assign total_sum = {1'b0, total_ff} + {{(TOTAL_W - 7){1'b0}}, cls};

   always_comb begin
      row_new         = row_cur;
      row_new[s1_bit] = 1'b1;
   end

   // accumulator next values and result
   always_comb begin
      run_in     = run_ff;
      total_in   = total_ff;
      max_in     = max_ff;
      marker_in  = marker_ff;
      covered_in = covered_ff;
      if (s1_trace && s1_in_map && s1_req_ff.map_index == 16'd0) begin
         marker_in = (s1_req_ff.hit_count == 8'd1);
      end
      if (hit) begin
         if (run_ff != RUN_MAX) run_in = run_ff + 1'b1;
         total_in = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
         if (cls > max_ff) max_in = cls;
      end
      if (set_new) begin
         covered_in = covered_ff + 1'b1;
      end

      rsp_in.class_value   = cls;
      rsp_in.run_tuples    = run_in;
      rsp_in.grand_total   = total_in;
      rsp_in.highest_value = max_in;
      rsp_in.marker_seen   = marker_in;
      rsp_in.covered_edges = covered_in;
      rsp_in.cover_bit     = s1_in_map && (row_cur[s1_bit] || set_new);
   end

   // memory write port: clearing pass or bit merge
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_row_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = advance && set_new;
         mem_waddr = s1_row;
         mem_wdata = row_new;
      end
   end

   // bitmap row memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rdata_ff <= mem[req_data.map_index[MEM_AW-1:BIT_AW]];
      end
   end

   // forwarding entry
   always_ff @(posedge clock) begin
      if (reset || state_ff == ST_CLEAR) begin
         hold_valid_ff <= 1'b0;
      end else if (mem_we) begin
         hold_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hold_row_ff  <= mem_waddr;
         hold_data_ff <= mem_wdata;
      end
   end

   // pipeline control and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
         total_ff     <= '0;
         max_ff       <= '0;
         marker_ff    <= 1'b0;
         covered_ff   <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            run_ff     <= (s1_trace && s1_req_ff.last) ? '0 : run_in;
            total_ff   <= total_in;
            max_ff     <= max_in;
            marker_ff  <= marker_in;
            covered_ff <= covered_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: coverage map classifier testbench
// Sends trace and read beats over valid/ready, mirrors the bucketing,
// accumulators and coverage bitmap in a scoreboard, and checks every result
// beat field by field under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cmca_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int SEGMENTS    = 12;
   localparam int SEG_BEATS   = 120;
   localparam int SWEEP_BEATS = 48;

   // mirror of the classifier state and the results still owed
   class hit_map_mirror;
      bit                 seen_map [INDEX_SPACE];
      logic [1:0]         mode;
      logic               collect;
      logic [RUN_W-1:0]   run_count;
      logic [TOTAL_W-1:0] total;
      logic [7:0]         peak;
      logic               marker;
      logic [RUN_W-1:0]   covered;
      rsp_type            due[$];
      int                 errors;

      function new();
         mode      = MODE_HUMAN;
         collect   = 1'b0;
         run_count = '0;
         total     = '0;
         peak      = '0;
         marker    = 1'b0;
         covered   = '0;
         errors    = 0;
      endfunction

      function int top_bit(logic [7:0] v);
         int pos;
         pos = -1;
         for (int i = 0; i < 8; i++)
            if (v[i]) pos = i;
         return pos;
      endfunction

      // bucket width follows the position of the leading one
      function logic [7:0] bucket(logic [7:0] v);
         int         msb;
         logic [7:0] r;
         msb = top_bit(v);
         case (mode)
            MODE_HUMAN: begin
               if (v < 8'd4)      r = v;
               else if (msb == 7) r = 8'd8;
               else               r = 8'((msb + 2 > 7) ? 7 : msb + 2);
            end
            MODE_POW2: begin
               if (v < 8'd3) r = v;
               else          r = 8'(1 << ((msb + 1 > 7) ? 7 : msb + 1));
            end
            MODE_EDGE: r = {7'd0, v != 8'd0};
            default:   r = v;
         endcase
         return r;
      endfunction

      function void accept_beat(req_type b);
         rsp_type    r;
         logic [7:0] v;
         r = '0;
         if (b.opcode == OP_TRACE) begin
            v = b.hit_count;
            // marker byte at position zero counts as empty
            if (b.map_index == 16'd0) begin
               marker = (v == 8'd1);
               if (v == 8'd1) v = 8'd0;
            end
            r.class_value = bucket(v);
            if (r.class_value != 8'd0) begin
               if (run_count != RUN_MAX) run_count++;
               if (TOTAL_MAX - total < TOTAL_W'(r.class_value)) total = TOTAL_MAX;
               else total = total + TOTAL_W'(r.class_value);
               if (r.class_value > peak) peak = r.class_value;
               if (collect && !seen_map[b.map_index]) begin
                  seen_map[b.map_index] = 1'b1;
                  covered++;
               end
            end
         end
         r.run_tuples    = run_count;
         r.grand_total   = total;
         r.highest_value = peak;
         r.marker_seen   = marker;
         r.covered_edges = covered;
         r.cover_bit     = seen_map[b.map_index];
         due.push_back(r);
         if (b.opcode == OP_TRACE && b.last) run_count = '0;
      endfunction

      function string show(rsp_type r);
         return $sformatf("class=%0d run=%0d total=%0d max=%0d marker=%0d covered=%0d bit=%0d",
                          r.class_value, r.run_tuples, r.grand_total, r.highest_value,
                          r.marker_seen, r.covered_edges, r.cover_bit);
      endfunction

      function void compare_beat(rsp_type got);
         rsp_type want;
         string   bad;
         if (due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat: %s", show(got));
            return;
         end
         want = due.pop_front();
         bad  = "";
         if (got.class_value !== want.class_value)     bad = {bad, " class_value"};
         if (got.run_tuples !== want.run_tuples)       bad = {bad, " run_tuples"};
         if (got.grand_total !== want.grand_total)     bad = {bad, " grand_total"};
         if (got.highest_value !== want.highest_value) bad = {bad, " highest_value"};
         if (got.marker_seen !== want.marker_seen)     bad = {bad, " marker_seen"};
         if (got.covered_edges !== want.covered_edges) bad = {bad, " covered_edges"};
         if (got.cover_bit !== want.cover_bit)         bad = {bad, " cover_bit"};
         if (bad != "") begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch in%s", bad);
               $display("  expected %s", show(want));
               $display("  actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;

   hit_map_mirror mirror = new();
   logic [15:0]   recent[$];
   int            beats_sent   = 0;
   int            quiet_cycles = 0;
   int            send_gap_pct = 0;
   int            stall_pct    = 0;

   coverage_map_classify_accumulate_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // beat monitor, scoreboard update and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) mirror.accept_beat(req_data);
         if (rsp_valid && rsp_ready) mirror.compare_beat(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // one request beat, held until accepted
   task automatic send_beat(input req_type b);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // hold off until every result is back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (mirror.due.size() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [1:0] mode, input logic collect);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_CLASSIFY_MODE;
      csr_wdata <= mode;
      mirror.mode = mode;
      @(negedge clock);
      csr_index <= CSR_COLLECT_COVERAGE;
      csr_wdata <= {1'b0, collect};
      mirror.collect = collect;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // hit count spread evenly over the bucket ranges
   function automatic logic [7:0] pick_count();
      logic [7:0] c;
      case ($urandom_range(9))
         0:       c = 8'd0;
         1:       c = 8'd1;
         2:       c = 8'd2;
         3:       c = 8'd3;
         4:       c = 8'($urandom_range(4, 7));
         5:       c = 8'($urandom_range(8, 15));
         6:       c = 8'($urandom_range(16, 31));
         7:       c = 8'($urandom_range(32, 63));
         8:       c = 8'($urandom_range(64, 127));
         default: c = 8'($urandom_range(128, 255));
      endcase
      return c;
   endfunction

   // mostly well-formed runs, some reads and some noise
   task automatic traffic(input int beats);
      int          goal;
      int          len;
      logic [15:0] base;
      logic [15:0] step;
      logic [15:0] at;
      logic [7:0]  cnt;
      req_type     b;
      goal = beats_sent + beats;
      while (beats_sent < goal) begin
         if ($urandom_range(9) == 0) begin
            // noise: fully random beats
            repeat ($urandom_range(1, 5)) begin
               b.opcode    = 1'($urandom_range(1));
               b.map_index = 16'($urandom);
               b.hit_count = 8'($urandom);
               b.last      = 1'($urandom_range(1));
               send_beat(b);
            end
         end else begin
            // one run: optional marker byte, sparse counts, usually a closing last
            base = 16'($urandom);
            step = 16'($urandom_range(1, 9));
            len  = $urandom_range(1, 40);
            if ($urandom_range(9) < 6) begin
               cnt = ($urandom_range(9) < 6) ? 8'd1 : pick_count();
               send_beat(req_type'{OP_TRACE, 16'd0, cnt, 1'b0});
            end
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(9) == 0) begin
                  at = (recent.size() != 0 && $urandom_range(9) < 7) ?
                       recent[$urandom_range(recent.size() - 1)] : 16'($urandom);
                  send_beat(req_type'{OP_READ, at, 8'($urandom), 1'($urandom_range(1))});
               end
               at  = base + 16'(k) * step;
               cnt = ($urandom_range(1) == 0) ? 8'd0 : pick_count();
               send_beat(req_type'{OP_TRACE, at, cnt,
                                   (k == len - 1) && ($urandom_range(9) != 0)});
               recent.push_back(at);
               if (recent.size() > 64) recent.delete(0);
               if ($urandom_range(199) == 0) drain_results();
            end
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_CLASSIFY_MODE;
      csr_wdata = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed beats: field extremes, marker set and cleared, reads
      configure(MODE_HUMAN, 1'b1);
      send_beat(req_type'{OP_TRACE, 16'd0,    8'd1,   1'b0});
      send_beat(req_type'{OP_TRACE, 16'hFFFF, 8'd255, 1'b0});
      send_beat(req_type'{OP_TRACE, 16'd1,    8'd0,   1'b0});
      send_beat(req_type'{OP_TRACE, 16'd2,    8'd128, 1'b0});
      send_beat(req_type'{OP_READ,  16'hFFFF, 8'd0,   1'b1});
      send_beat(req_type'{OP_READ,  16'd3,    8'hFF,  1'b0});
      send_beat(req_type'{OP_TRACE, 16'd0,    8'd0,   1'b0});
      send_beat(req_type'{OP_TRACE, 16'd0,    8'd1,   1'b1});
      send_beat(req_type'{OP_TRACE, 16'd0,    8'd255, 1'b0});
      send_beat(req_type'{OP_TRACE, 16'h8000, 8'd127, 1'b1});
      send_beat(req_type'{OP_READ,  16'd0,    8'd255, 1'b0});
      send_beat(req_type'{OP_READ,  16'h8000, 8'd0,   1'b1});
      send_beat(req_type'{OP_TRACE, 16'h5555, 8'hAA,  1'b1});
      send_beat(req_type'{OP_TRACE, 16'hAAAA, 8'h55,  1'b0});

      // random segments over every mode and collect setting
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_results();
         configure(2'(seg % 4), 1'((seg + seg / 4) % 2));
         case (seg / 4)
            0: begin
               send_gap_pct = 15;
               stall_pct    = 46;
            end
            1: begin
               send_gap_pct = 46;
               stall_pct    = 15;
            end
            default: begin
               send_gap_pct = 0;
               stall_pct    = 0;
            end
         endcase
         traffic(SEG_BEATS);
      end

      // one raw run over consecutive positions with coverage on, then a read
      drain_results();
      configure(MODE_RAW, 1'b1);
      for (int i = 0; i < SWEEP_BEATS; i++)
         send_beat(req_type'{OP_TRACE, 16'(i + 1), 8'($urandom_range(2, 255)),
                             i == SWEEP_BEATS - 1});
      send_beat(req_type'{OP_READ, 16'($urandom), 8'd0, 1'b0});

      drain_results();
      repeat (8) @(posedge clock);
      if (mirror.errors == 0 && mirror.due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
